>>> rtl/core/pofs_pkg.sv
// ----------------------------------------------------------------------------
// pofs_pkg
// shared types, codes and constants of the oscillator force stencil
// ----------------------------------------------------------------------------
package pofs_pkg;

    // default store geometry
    localparam int DEF_MAX_SLICES = 64;
    localparam int DEF_MAX_SITES  = 64;

    // command queue and result queue depths
    localparam int OP_QUEUE_DEPTH  = 4;
    localparam int RESULT_DEPTH    = 4;

    // configuration register indexes
    localparam logic [2:0] REG_OMEGA     = 3'd0;
    localparam logic [2:0] REG_INV_OMEGA = 3'd1;
    localparam logic [2:0] REG_SITES     = 3'd2;
    localparam logic [2:0] REG_SLICES    = 3'd3;
    localparam logic [2:0] REG_CLEAR     = 3'd4;

    // input commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    // fraction bits of omega and inv_omega
    localparam int COEF_FRAC = 24;

    // reset values
    localparam logic [31:0] COEF_ONE = 32'h0100_0000;

    // arithmetic settings seen by the back end
    typedef struct packed {
        logic [31:0] omega;
        logic [31:0] inv_omega;
        logic        clear;
    } pofs_cfg_t;

    // address width for a store of the given depth
    function automatic int pos_width(input int depth);
        pos_width = (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // width of one queued operation: command, last, three addresses, two values
    function automatic int op_width(input int depth);
        op_width = 2 + 3 * pos_width(depth) + 64;
    endfunction

endpackage

>>> rtl/core/pofs_queue.sv
// ----------------------------------------------------------------------------
// pofs_queue
// small register queue used between front and back and on the result side
// ----------------------------------------------------------------------------
module pofs_queue
    import pofs_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/pofs_front.sv
// ----------------------------------------------------------------------------
// pofs_front
// config registers, item intake and stencil address generation
// ----------------------------------------------------------------------------
module pofs_front
    import pofs_pkg::*;
#(
    parameter int MAX_SLICES = DEF_MAX_SLICES,
    parameter int MAX_SITES  = DEF_MAX_SITES
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [2:0]                                 cfg_index,
    input  logic [31:0]                                cfg_data,
    input  logic                                       s_valid,
    output logic                                       s_ready,
    input  logic                                       s_command,
    input  logic signed [31:0]                         s_x_value,
    input  logic signed [31:0]                         s_force_in,
    output pofs_cfg_t                                  arith_cfg,
    output logic                                       op_push,
    output logic [op_width(MAX_SLICES*MAX_SITES)-1:0]  op_data,
    input  logic                                       op_full
);

    localparam int DEPTH    = MAX_SLICES * MAX_SITES;
    localparam int POS_W    = pos_width(DEPTH);
    localparam int SITE_CW  = $clog2(MAX_SITES + 1);
    localparam int SLICE_CW = $clog2(MAX_SLICES + 1);
    localparam int POS_CW   = SITE_CW + SLICE_CW;

    logic [31:0]         omega_reg, inv_omega_reg;
    logic [6:0]          sites_reg, slices_reg;
    logic                clear_reg;

    logic [POS_W-1:0]    load_pos_reg, load_pos_next;
    logic [POS_W-1:0]    emit_pos_reg, emit_pos_next;
    logic [SITE_CW-1:0]  emit_site_reg, emit_site_next;
    logic [SLICE_CW-1:0] emit_tau_reg, emit_tau_next;

    logic [SITE_CW-1:0]  eff_ns;
    logic [SLICE_CW-1:0] eff_nt;
    logic [POS_CW-1:0]   total, wrap_off, emit_ext, load_ext;
    logic [POS_CW-1:0]   nxt_full, prv_full;
    logic                emit_last, load_last;
    logic                s_accept, cfg_write, size_write;

    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign size_write = cfg_write && (cfg_index == REG_SITES || cfg_index == REG_SLICES);
    assign s_ready    = !op_full;
    assign s_accept   = s_valid && s_ready;

    assign arith_cfg.omega     = omega_reg;
    assign arith_cfg.inv_omega = inv_omega_reg;
    assign arith_cfg.clear     = clear_reg;

    // clamp sizes into the store geometry
    always_comb begin
        if (sites_reg == '0) begin
            eff_ns = SITE_CW'(1);
        end else if (int'(sites_reg) > MAX_SITES) begin
            eff_ns = SITE_CW'(MAX_SITES);
        end else begin
            eff_ns = SITE_CW'(sites_reg);
        end
        if (slices_reg == '0) begin
            eff_nt = SLICE_CW'(1);
        end else if (int'(slices_reg) > MAX_SLICES) begin
            eff_nt = SLICE_CW'(MAX_SLICES);
        end else begin
            eff_nt = SLICE_CW'(slices_reg);
        end
    end

    assign total    = POS_CW'(eff_ns) * POS_CW'(eff_nt);
    assign wrap_off = total - POS_CW'(eff_ns);
    assign emit_ext = POS_CW'(emit_pos_reg);
    assign load_ext = POS_CW'(load_pos_reg);

    // neighbors in time, wrapping at the first and last slice
    assign nxt_full  = (emit_tau_reg == eff_nt - 1'b1) ? emit_ext - wrap_off
                                                      : emit_ext + POS_CW'(eff_ns);
    assign prv_full  = (emit_tau_reg == '0) ? emit_ext + wrap_off
                                            : emit_ext - POS_CW'(eff_ns);
    assign emit_last = (emit_ext + 1'b1 == total);
    assign load_last = (load_ext + 1'b1 == total);

    assign op_push = s_accept;
    always_comb begin
        if (s_command == CMD_LOAD) begin
            op_data = {CMD_LOAD, 1'b0, load_pos_reg, load_pos_reg, load_pos_reg,
                       s_x_value, s_force_in};
        end else begin
            op_data = {CMD_EMIT, emit_last, emit_pos_reg, nxt_full[POS_W-1:0],
                       prv_full[POS_W-1:0], s_x_value, s_force_in};
        end
    end

    always_comb begin
        load_pos_next  = load_pos_reg;
        emit_pos_next  = emit_pos_reg;
        emit_site_next = emit_site_reg;
        emit_tau_next  = emit_tau_reg;
        if (size_write) begin
            load_pos_next  = '0;
            emit_pos_next  = '0;
            emit_site_next = '0;
            emit_tau_next  = '0;
        end else if (s_accept) begin
            if (s_command == CMD_LOAD) begin
                load_pos_next = load_last ? '0 : load_pos_reg + 1'b1;
            end else if (emit_last) begin
                emit_pos_next  = '0;
                emit_site_next = '0;
                emit_tau_next  = '0;
            end else begin
                emit_pos_next = emit_pos_reg + 1'b1;
                if (emit_site_reg + 1'b1 == eff_ns) begin
                    emit_site_next = '0;
                    emit_tau_next  = emit_tau_reg + 1'b1;
                end else begin
                    emit_site_next = emit_site_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            omega_reg     <= COEF_ONE;
            inv_omega_reg <= COEF_ONE;
            sites_reg     <= 7'd1;
            slices_reg    <= 7'd1;
            clear_reg     <= 1'b1;
            load_pos_reg  <= '0;
            emit_pos_reg  <= '0;
            emit_site_reg <= '0;
            emit_tau_reg  <= '0;
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    REG_OMEGA:     omega_reg     <= cfg_data;
                    REG_INV_OMEGA: inv_omega_reg <= cfg_data;
                    REG_SITES:     sites_reg     <= cfg_data[6:0];
                    REG_SLICES:    slices_reg    <= cfg_data[6:0];
                    REG_CLEAR:     clear_reg     <= cfg_data[0];
                    default: ;
                endcase
            end
            load_pos_reg  <= load_pos_next;
            emit_pos_reg  <= emit_pos_next;
            emit_site_reg <= emit_site_next;
            emit_tau_reg  <= emit_tau_next;
        end
    end

endmodule

>>> rtl/core/pofs_back.sv
// ----------------------------------------------------------------------------
// pofs_back
// field stores, read sequencer and force arithmetic pipeline
// ----------------------------------------------------------------------------
module pofs_back
    import pofs_pkg::*;
#(
    parameter int MAX_SLICES = DEF_MAX_SLICES,
    parameter int MAX_SITES  = DEF_MAX_SITES
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  pofs_cfg_t                                  arith_cfg,
    input  logic                                       op_empty,
    input  logic [op_width(MAX_SLICES*MAX_SITES)-1:0]  op_data,
    output logic                                       op_pop,
    output logic                                       res_push,
    output logic [32:0]                                res_data,
    input  logic                                       res_taken
);

    localparam int DEPTH = MAX_SLICES * MAX_SITES;
    localparam int POS_W = pos_width(DEPTH);
    localparam int OP_W  = op_width(DEPTH);
    localparam int CRD_W = $clog2(RESULT_DEPTH + 1);
    localparam logic signed [67:0] HALF_LSB = 68'sd1 <<< (COEF_FRAC - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_NXT  = 3'b010,
        ST_PRV  = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;

    logic signed [31:0] field_mem [DEPTH];
    logic signed [31:0] prior_mem [DEPTH];
    logic signed [31:0] fld_rdata_reg, pri_rdata_reg;

    logic               op_cmd, op_last;
    logic [POS_W-1:0]   op_addr_a, op_addr_n, op_addr_p;
    logic signed [31:0] op_x, op_f;
    logic               emit_pop, load_pop;
    logic [POS_W-1:0]   fld_addr;
    logic               fld_re;

    logic [CRD_W-1:0]   credit_reg, credit_next;

    logic [POS_W-1:0]   addr_n_reg, addr_p_reg;
    logic               last_hold_reg;
    logic signed [31:0] x_hold_reg, xn_hold_reg, base_hold_reg;
    logic               g_valid_reg, g_last_reg;

    logic               v1_reg, v2_reg, v3_reg;
    logic               last1_reg, last2_reg, last3_reg;
    logic signed [33:0] d1_reg, d1_next;
    logic signed [31:0] x1_reg, base1_reg, base2_reg, base3_reg;
    logic signed [64:0] sp2_reg;
    logic signed [50:0] hi2_reg, lo2_reg;
    logic signed [41:0] spring3_reg;
    logic signed [43:0] scaled3_reg;
    logic signed [67:0] sp_sum, sc_sum;
    logic signed [45:0] f_sum;
    logic signed [31:0] f_sat;

    // unpack the queued operation
    assign op_cmd    = op_data[OP_W-1];
    assign op_last   = op_data[OP_W-2];
    assign op_addr_a = op_data[OP_W-3 -: POS_W];
    assign op_addr_n = op_data[OP_W-3-POS_W -: POS_W];
    assign op_addr_p = op_data[OP_W-3-2*POS_W -: POS_W];
    assign op_x      = op_data[63:32];
    assign op_f      = op_data[31:0];

    // an emit starts only with room reserved in the result queue
    assign op_pop   = (state_reg == ST_IDLE) && !op_empty
                      && (op_cmd == CMD_LOAD || credit_reg < CRD_W'(RESULT_DEPTH));
    assign load_pop = op_pop && (op_cmd == CMD_LOAD);
    assign emit_pop = op_pop && (op_cmd == CMD_EMIT);

    always_comb begin
        state_next = state_reg;
        fld_addr   = op_addr_a;
        fld_re     = emit_pop;
        case (state_reg)
            ST_IDLE: begin
                if (emit_pop) begin
                    state_next = ST_NXT;
                end
            end
            ST_NXT: begin
                fld_addr   = addr_n_reg;
                fld_re     = 1'b1;
                state_next = ST_PRV;
            end
            ST_PRV: begin
                fld_addr   = addr_p_reg;
                fld_re     = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        credit_next = credit_reg;
        if (emit_pop && !res_taken) begin
            credit_next = credit_reg + 1'b1;
        end else if (res_taken && !emit_pop) begin
            credit_next = credit_reg - 1'b1;
        end
    end

    // single port field store: one write or one read a cycle
    always_ff @(posedge aclk) begin
        if (load_pop) begin
            field_mem[fld_addr] <= op_x;
        end else if (fld_re) begin
            fld_rdata_reg <= field_mem[fld_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (load_pop) begin
            prior_mem[op_addr_a] <= op_f;
        end else if (emit_pop) begin
            pri_rdata_reg <= prior_mem[op_addr_a];
        end
    end

    // second difference, exact in 34 bits
    assign d1_next = 34'(xn_hold_reg) + 34'(fld_rdata_reg) - (34'(x_hold_reg) <<< 1);

    // round half up, then drop the coefficient fraction
    assign sp_sum = 68'(sp2_reg) + HALF_LSB;
    assign sc_sum = (68'(hi2_reg) <<< 16) + 68'(lo2_reg) + HALF_LSB;

    assign f_sum = 46'(base3_reg) - 46'(spring3_reg) + 46'(scaled3_reg);
    always_comb begin
        if (f_sum > 46'sd2147483647) begin
            f_sat = 32'sh7FFF_FFFF;
        end else if (f_sum < -46'sd2147483648) begin
            f_sat = -32'sh8000_0000;
        end else begin
            f_sat = f_sum[31:0];
        end
    end

    assign res_push = v3_reg;
    assign res_data = {last3_reg, f_sat};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            credit_reg  <= '0;
            g_valid_reg <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            credit_reg  <= credit_next;
            g_valid_reg <= (state_reg == ST_PRV);
            v1_reg      <= g_valid_reg;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
        end
    end

    // operand gathering and arithmetic payload
    always_ff @(posedge aclk) begin
        if (emit_pop) begin
            addr_n_reg    <= op_addr_n;
            addr_p_reg    <= op_addr_p;
            last_hold_reg <= op_last;
        end
        if (state_reg == ST_NXT) begin
            x_hold_reg    <= fld_rdata_reg;
            base_hold_reg <= arith_cfg.clear ? 32'sd0 : pri_rdata_reg;
        end
        if (state_reg == ST_PRV) begin
            xn_hold_reg <= fld_rdata_reg;
            g_last_reg  <= last_hold_reg;
        end
        if (g_valid_reg) begin
            d1_reg    <= d1_next;
            x1_reg    <= x_hold_reg;
            base1_reg <= base_hold_reg;
            last1_reg <= g_last_reg;
        end
        if (v1_reg) begin
            sp2_reg   <= x1_reg * $signed({1'b0, arith_cfg.omega});
            hi2_reg   <= d1_reg * $signed({1'b0, arith_cfg.inv_omega[31:16]});
            lo2_reg   <= d1_reg * $signed({1'b0, arith_cfg.inv_omega[15:0]});
            base2_reg <= base1_reg;
            last2_reg <= last1_reg;
        end
        if (v2_reg) begin
            spring3_reg <= 42'(sp_sum >>> COEF_FRAC);
            scaled3_reg <= 44'(sc_sum >>> COEF_FRAC);
            base3_reg   <= base2_reg;
            last3_reg   <= last2_reg;
        end
    end

endmodule

>>> rtl/core/periodic_oscillator_force_stencil.sv
// ----------------------------------------------------------------------------
// periodic_oscillator_force_stencil
// harmonic oscillator force with a periodic second difference in time
// ----------------------------------------------------------------------------
// sequencing: a load item needs only a write to each store; an emit item holds
//   the back end for three reads (current, next and previous slice) on the one
//   field store port, and no new item is taken until they are done; an emit
//   result then passes ST_NXT, ST_PRV, g_valid, v1, v2, v3 and the result queue
// reset: aresetn is synchronous, active low; registers return to their
//   defaults and both positions to zero; the stores are not cleared
// ----------------------------------------------------------------------------
module periodic_oscillator_force_stencil
    import pofs_pkg::*;
#(
    parameter int MAX_SLICES = DEF_MAX_SLICES,
    parameter int MAX_SITES  = DEF_MAX_SITES
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    // input items
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic signed [31:0] s_x_value,
    input  logic signed [31:0] s_force_in,
    // result items
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_force_out,
    output logic               m_last
);

    localparam int OP_W = op_width(MAX_SLICES * MAX_SITES);

    pofs_cfg_t        arith_cfg;

    // front to back operation queue
    logic             op_push, op_full, op_pop, op_empty;
    logic [OP_W-1:0]  op_push_data, op_pop_data;

    // back to result queue
    logic             res_push, res_full, res_empty, res_taken;
    logic [32:0]      res_push_data, res_pop_data;

    // front: config registers, intake, neighbor addresses per item
    pofs_front #(
        .MAX_SLICES (MAX_SLICES),
        .MAX_SITES  (MAX_SITES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_x_value  (s_x_value),
        .s_force_in (s_force_in),
        .arith_cfg  (arith_cfg),
        .op_push    (op_push),
        .op_data    (op_push_data),
        .op_full    (op_full)
    );

    // short queue so intake keeps going while the back end reads
    pofs_queue #(
        .WIDTH (OP_W),
        .DEPTH (OP_QUEUE_DEPTH)
    ) u_op_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (op_push),
        .push_data (op_push_data),
        .full      (op_full),
        .pop       (op_pop),
        .pop_data  (op_pop_data),
        .empty     (op_empty)
    );

    // back: stores, read sequencer, arithmetic pipeline
    pofs_back #(
        .MAX_SLICES (MAX_SLICES),
        .MAX_SITES  (MAX_SITES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .arith_cfg (arith_cfg),
        .op_empty  (op_empty),
        .op_data   (op_pop_data),
        .op_pop    (op_pop),
        .res_push  (res_push),
        .res_data  (res_push_data),
        .res_taken (res_taken)
    );

    // result queue; the back end reserves a slot per emit item, so it never overflows
    assign res_taken = m_valid && m_ready;

    pofs_queue #(
        .WIDTH (33),
        .DEPTH (RESULT_DEPTH)
    ) u_res_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res_push_data),
        .full      (res_full),
        .pop       (res_taken),
        .pop_data  (res_pop_data),
        .empty     (res_empty)
    );

    assign m_valid     = !res_empty && !res_full | !res_empty;
    assign m_force_out = res_pop_data[31:0];
    assign m_last      = res_pop_data[32];

endmodule
